[design/rbcf_pkg.sv]
// Shared widths, payload structs, register indexes and the microprogram
// of the crossfading biquad. No dependencies.
`timescale 1ns / 1ps

package rbcf_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 17;
  localparam int COEF_FRAC = 16;
  localparam int LEN_W     = 24;
  localparam int CNT_W     = LEN_W + 1;
  localparam int NCOEF     = 5;
  localparam int NCHAN     = 2;

  // Datapath widths
  localparam int MUL_A_W   = LEN_W + 1;
  localparam int MUL_B_W   = COEF_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int NUM_W     = COEF_W + LEN_W;
  localparam int DCNT_W    = $clog2(LEN_W + 1);

  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(2 ** COEF_FRAC);
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(2 ** (COEF_FRAC - 1));

  localparam logic [LEN_W-1:0]  CYCLE_LENGTH_RST    = LEN_W'(24000);
  localparam logic [COEF_W-1:0] SMOOTH_FRACTION_RST = COEF_W'(1966);

  // Configuration register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_CYCLE_LENGTH    = 2'd0;
  localparam reg_index_t REG_SMOOTH_FRACTION = 2'd1;
  localparam reg_index_t REG_HOST_SYNC       = 2'd2;

  // Coefficient / filter term indexes
  typedef logic [2:0] coef_idx_t;
  localparam coef_idx_t K_A0 = 3'd0;
  localparam coef_idx_t K_A1 = 3'd1;
  localparam coef_idx_t K_A2 = 3'd2;
  localparam coef_idx_t K_B1 = 3'd3;
  localparam coef_idx_t K_B2 = 3'd4;

  // Channel payloads
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic [COEF_W-1:0]          next_a0;
    logic [COEF_W-1:0]          next_a1;
    logic [COEF_W-1:0]          next_a2;
    logic [COEF_W-1:0]          next_b1;
    logic [COEF_W-1:0]          next_b2;
    logic                       playback_restart;
    logic [LEN_W-1:0]           samples_to_bar;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [COEF_W-1:0]          coef_a0;
    logic [COEF_W-1:0]          coef_a1;
    logic [COEF_W-1:0]          coef_a2;
    logic [COEF_W-1:0]          coef_b1;
    logic [COEF_W-1:0]          coef_b2;
  } result_t;

  // Datapath operations driven by the control word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LEN,
    OP_DIV_STEP,
    OP_LOAD,
    OP_SPAN,
    OP_FADE_INIT,
    OP_FMUL_T,
    OP_FMUL_S,
    OP_FSUM,
    OP_FDIV_INIT,
    OP_FSTORE,
    OP_FADE_END,
    OP_FILT_INIT,
    OP_MAC_MUL,
    OP_MAC_ADD,
    OP_ROUND,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_RUNNING,
    C_NO_RESYNC,
    C_DIV_MORE,
    C_FADE_OFF,
    C_MORE_COEF,
    C_MORE_TERM,
    C_MORE_CH,
    C_OUT_BUSY
  } cond_t;

  // Program addresses
  typedef logic [4:0] pc_t;
  localparam pc_t P_IDLE    = 5'd0;
  localparam pc_t P_CHECK   = 5'd1;
  localparam pc_t P_LEN     = 5'd2;
  localparam pc_t P_MOD     = 5'd3;
  localparam pc_t P_LOAD    = 5'd4;
  localparam pc_t P_SPAN    = 5'd5;
  localparam pc_t P_FADECHK = 5'd6;
  localparam pc_t P_FMUL_T  = 5'd7;
  localparam pc_t P_FMUL_S  = 5'd8;
  localparam pc_t P_FSUM    = 5'd9;
  localparam pc_t P_FDIVI   = 5'd10;
  localparam pc_t P_FDIV    = 5'd11;
  localparam pc_t P_FSTORE  = 5'd12;
  localparam pc_t P_FEND    = 5'd13;
  localparam pc_t P_FILT    = 5'd14;
  localparam pc_t P_MUL     = 5'd15;
  localparam pc_t P_ADD     = 5'd16;
  localparam pc_t P_ROUND   = 5'd17;
  localparam pc_t P_OUT     = 5'd18;
  localparam pc_t P_WRAP    = 5'd19;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      P_IDLE:    w = '{OP_ACCEPT,    C_NO_REQ,    P_IDLE};
      P_CHECK:   w = '{OP_NOP,       C_RUNNING,   P_FADECHK};
      P_LEN:     w = '{OP_LEN,       C_NO_RESYNC, P_LOAD};
      P_MOD:     w = '{OP_DIV_STEP,  C_DIV_MORE,  P_MOD};
      P_LOAD:    w = '{OP_LOAD,      C_NEXT,      P_IDLE};
      P_SPAN:    w = '{OP_SPAN,      C_NEXT,      P_IDLE};
      P_FADECHK: w = '{OP_FADE_INIT, C_FADE_OFF,  P_FILT};
      P_FMUL_T:  w = '{OP_FMUL_T,    C_NEXT,      P_IDLE};
      P_FMUL_S:  w = '{OP_FMUL_S,    C_NEXT,      P_IDLE};
      P_FSUM:    w = '{OP_FSUM,      C_NEXT,      P_IDLE};
      P_FDIVI:   w = '{OP_FDIV_INIT, C_NEXT,      P_IDLE};
      P_FDIV:    w = '{OP_DIV_STEP,  C_DIV_MORE,  P_FDIV};
      P_FSTORE:  w = '{OP_FSTORE,    C_MORE_COEF, P_FMUL_T};
      P_FEND:    w = '{OP_FADE_END,  C_NEXT,      P_IDLE};
      P_FILT:    w = '{OP_FILT_INIT, C_NEXT,      P_IDLE};
      P_MUL:     w = '{OP_MAC_MUL,   C_NEXT,      P_IDLE};
      P_ADD:     w = '{OP_MAC_ADD,   C_MORE_TERM, P_MUL};
      P_ROUND:   w = '{OP_ROUND,     C_MORE_CH,   P_FILT};
      P_OUT:     w = '{OP_EMIT,      C_OUT_BUSY,  P_OUT};
      P_WRAP:    w = '{OP_NOP,       C_ALWAYS,    P_IDLE};
      default:   w = '{OP_NOP,       C_ALWAYS,    P_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/rbcf_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Payload types come from rbcf_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface rbcf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/random_biquad_crossfade_filter.sv]
// Stereo direct form I biquad with per-cycle coefficient crossfade.
// Depends on rbcf_pkg and rbcf_stream_if.
`timescale 1ns / 1ps

// One stereo frame is taken per request on frame and gives one request on
// result. A microcoded sequencer runs each frame through one shared
// 25x18 multiplier and a one-bit-per-cycle restoring divider. A frame inside
// the crossfade span adds the crossfade steps, among them five coefficient
// divisions of 17 steps; a cycle-start frame adds the length, load and span
// steps, plus 24 divider steps when a bar resync is taken. The result sits
// in an output register, so the next frame is taken while it waits; the
// sequencer stalls only if a new result is ready before the old one left.
// Configuration writes are to be issued while no frame is in flight.
module random_biquad_crossfade_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rbcf_pkg::reg_index_t wr_index,
  input  logic [rbcf_pkg::LEN_W-1:0] wr_data,
  rbcf_stream_if.sink         frame,
  rbcf_stream_if.source       result
);

  localparam int SAMPLE_W  = rbcf_pkg::SAMPLE_W;
  localparam int COEF_W    = rbcf_pkg::COEF_W;
  localparam int COEF_FRAC = rbcf_pkg::COEF_FRAC;
  localparam int LEN_W     = rbcf_pkg::LEN_W;
  localparam int CNT_W     = rbcf_pkg::CNT_W;
  localparam int NCOEF     = rbcf_pkg::NCOEF;
  localparam int NCHAN     = rbcf_pkg::NCHAN;
  localparam int MUL_A_W   = rbcf_pkg::MUL_A_W;
  localparam int MUL_B_W   = rbcf_pkg::MUL_B_W;
  localparam int PROD_W    = rbcf_pkg::PROD_W;
  localparam int ACC_W     = rbcf_pkg::ACC_W;
  localparam int NUM_W     = rbcf_pkg::NUM_W;
  localparam int DCNT_W    = rbcf_pkg::DCNT_W;

  localparam logic [COEF_W-1:0] ONE  = rbcf_pkg::COEF_ONE;
  localparam logic [COEF_W-1:0] HALF = rbcf_pkg::COEF_HALF;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (COEF_FRAC - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic CH_LAST = 1'b1;

  function automatic logic [COEF_W-1:0] coef_sat(input logic [COEF_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Sequencer
  rbcf_pkg::pc_t    pc, pc_next;
  rbcf_pkg::uword_t uw;
  logic             taken;

  // Configuration
  logic [LEN_W-1:0]  cycle_length;
  logic [COEF_W-1:0] smooth_fraction;
  logic              host_sync;

  // Filter and crossfade state
  logic signed [CNT_W-1:0] cycle_counter;
  logic signed [CNT_W-1:0] smooth_counter;
  logic [LEN_W-1:0]        smooth_span;
  logic                    resync_pending;
  logic [COEF_W-1:0]       live   [NCOEF];
  logic [COEF_W-1:0]       start  [NCOEF];
  logic [COEF_W-1:0]       target [NCOEF];
  logic signed [SAMPLE_W-1:0] hx1 [NCHAN];
  logic signed [SAMPLE_W-1:0] hx2 [NCHAN];
  logic signed [SAMPLE_W-1:0] hy1 [NCHAN];
  logic signed [SAMPLE_W-1:0] hy2 [NCHAN];

  // Frame registers
  logic signed [SAMPLE_W-1:0] x_in   [NCHAN];
  logic [COEF_W-1:0]          tgt_in [NCOEF];
  logic [COEF_W-1:0]          nxt    [NCOEF];
  logic [LEN_W-1:0]           stb;
  logic                       resync_now;
  logic [LEN_W-1:0]           len_reg;

  // Datapath registers
  rbcf_pkg::coef_idx_t     k, j;
  logic                    ch;
  logic signed [PROD_W-1:0] prod;
  logic [NUM_W-1:0]        num;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] y_out [NCHAN];
  logic [LEN_W-1:0]        div_rem, div_bits, div_quot, div_den;
  logic [DCNT_W-1:0]       div_cnt;

  // Output register
  rbcf_pkg::result_t res_q;
  logic              res_valid;

  // Combinational datapath
  logic [LEN_W-1:0]           len_eff, len_sel, fade_s, ss;
  logic [COEF_W-1:0]          frac_sat;
  logic [NUM_W-1:0]           ss_full;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul;
  logic signed [SAMPLE_W-1:0] tap;
  logic [LEN_W:0]             trial, diff;
  logic                       ge;
  logic signed [ACC_W-1:0]    rsum, rsh;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       accept, out_free, emit_fire;

  assign uw        = rbcf_pkg::ucode(pc);
  assign accept    = frame.valid && (uw.op == rbcf_pkg::OP_ACCEPT) && !rst;
  assign out_free  = !res_valid || result.ready;
  assign emit_fire = (uw.op == rbcf_pkg::OP_EMIT) && out_free;

  // no request is taken while in reset
  assign frame.ready    = (uw.op == rbcf_pkg::OP_ACCEPT) && !rst;
  assign result.valid   = res_valid;
  assign result.payload = res_q;

  assign nxt[rbcf_pkg::K_A0] = frame.payload.next_a0;
  assign nxt[rbcf_pkg::K_A1] = frame.payload.next_a1;
  assign nxt[rbcf_pkg::K_A2] = frame.payload.next_a2;
  assign nxt[rbcf_pkg::K_B1] = frame.payload.next_b1;
  assign nxt[rbcf_pkg::K_B2] = frame.payload.next_b2;

  // Cycle length, fade fraction and fade position
  assign len_eff  = (cycle_length == '0) ? LEN_W'(1) : cycle_length;
  assign frac_sat = coef_sat(smooth_fraction);
  assign len_sel  = resync_now ? div_rem : len_reg;
  assign fade_s   = (smooth_counter[LEN_W-1:0] > smooth_span) ? smooth_span
                                                              : smooth_counter[LEN_W-1:0];
  assign ss_full  = prod[NUM_W-1:0] + NUM_W'(HALF);
  assign ss       = ss_full[COEF_FRAC +: LEN_W];

  // Filter tap for the current term
  always_comb begin
    case (j)
      rbcf_pkg::K_A0: tap = x_in[ch];
      rbcf_pkg::K_A1: tap = hx1[ch];
      rbcf_pkg::K_A2: tap = hx2[ch];
      rbcf_pkg::K_B1: tap = hy1[ch];
      default:        tap = hy2[ch];
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    case (uw.op)
      rbcf_pkg::OP_LOAD: begin
        mul_a = {1'b0, len_sel};
        mul_b = {1'b0, frac_sat};
      end
      rbcf_pkg::OP_FMUL_T: begin
        mul_a = {1'b0, smooth_span - fade_s};
        mul_b = {1'b0, target[k]};
      end
      rbcf_pkg::OP_FMUL_S: begin
        mul_a = {1'b0, fade_s};
        mul_b = {1'b0, start[k]};
      end
      default: begin
        mul_a = {tap[SAMPLE_W-1], tap};
        mul_b = {1'b0, live[j]};
      end
    endcase
  end

  assign mul = mul_a * mul_b;

  // Restoring divider step
  assign trial = {div_rem, div_bits[LEN_W-1]};
  assign ge    = trial >= {1'b0, div_den};
  assign diff  = trial - {1'b0, div_den};

  // Round half up and saturate
  assign rsum = acc + ROUND_BIAS;
  assign rsh  = rsum >>> COEF_FRAC;
  always_comb begin
    if (rsh > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_W-1:0];
    end else if (rsh < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      y_sat = rsh[SAMPLE_W-1:0];
    end
  end

  // Jump condition and next step
  always_comb begin
    case (uw.cond)
      rbcf_pkg::C_NEXT:      taken = 1'b0;
      rbcf_pkg::C_ALWAYS:    taken = 1'b1;
      rbcf_pkg::C_NO_REQ:    taken = !frame.valid;
      rbcf_pkg::C_RUNNING:   taken = !cycle_counter[CNT_W-1] && (cycle_counter != '0);
      rbcf_pkg::C_NO_RESYNC: taken = !resync_pending;
      rbcf_pkg::C_DIV_MORE:  taken = (div_cnt != DCNT_W'(1));
      rbcf_pkg::C_FADE_OFF:  taken = smooth_counter[CNT_W-1];
      rbcf_pkg::C_MORE_COEF: taken = (k != rbcf_pkg::K_B2);
      rbcf_pkg::C_MORE_TERM: taken = (j != rbcf_pkg::K_B2);
      rbcf_pkg::C_MORE_CH:   taken = (ch != CH_LAST);
      rbcf_pkg::C_OUT_BUSY:  taken = !out_free;
      default:               taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc + rbcf_pkg::pc_t'(1);
  end

  // Step counter, configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= rbcf_pkg::P_IDLE;
      cycle_length    <= rbcf_pkg::CYCLE_LENGTH_RST;
      smooth_fraction <= rbcf_pkg::SMOOTH_FRACTION_RST;
      host_sync       <= 1'b1;
      cycle_counter   <= CNT_W'(1);
      smooth_counter  <= CNT_W'(1);
      smooth_span     <= LEN_W'(1);
      resync_pending  <= 1'b1;
      res_valid       <= 1'b0;
      for (int i = 0; i < NCOEF; i++) begin
        live[i]   <= HALF;
        start[i]  <= '0;
        target[i] <= '0;
      end
      for (int c = 0; c < NCHAN; c++) begin
        hx1[c] <= '0;
        hx2[c] <= '0;
        hy1[c] <= '0;
        hy2[c] <= '0;
      end
    end else begin
      pc <= pc_next;

      if (wr_en) begin
        case (wr_index)
          rbcf_pkg::REG_CYCLE_LENGTH:    cycle_length    <= wr_data;
          rbcf_pkg::REG_SMOOTH_FRACTION: smooth_fraction <= wr_data[COEF_W-1:0];
          rbcf_pkg::REG_HOST_SYNC:       host_sync       <= wr_data[0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (uw.op)
        rbcf_pkg::OP_ACCEPT: begin
          if (accept) begin
            // with host sync set, restart forces the counter to zero before the decrement
            cycle_counter  <= ((host_sync && frame.payload.playback_restart) ? '0
                                                                            : cycle_counter)
                              - CNT_W'(1);
            resync_pending <= host_sync && (resync_pending || frame.payload.playback_restart);
          end
        end
        rbcf_pkg::OP_LEN: begin
          resync_pending <= 1'b0;
        end
        rbcf_pkg::OP_LOAD: begin
          cycle_counter <= {1'b0, len_sel};
          for (int i = 0; i < NCOEF; i++) begin
            start[i]  <= live[i];
            target[i] <= tgt_in[i];
          end
        end
        rbcf_pkg::OP_SPAN: begin
          smooth_counter <= {1'b0, ss};
          smooth_span    <= (ss == '0) ? LEN_W'(1) : ss;
        end
        rbcf_pkg::OP_FSTORE: begin
          live[k] <= div_quot[COEF_W-1:0];
        end
        rbcf_pkg::OP_FADE_END: begin
          smooth_counter <= smooth_counter - CNT_W'(1);
        end
        rbcf_pkg::OP_ROUND: begin
          hx2[ch] <= hx1[ch];
          hx1[ch] <= x_in[ch];
          hy2[ch] <= hy1[ch];
          hy1[ch] <= y_sat;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (uw.op)
      rbcf_pkg::OP_ACCEPT: begin
        if (accept) begin
          x_in[0] <= frame.payload.in_left;
          x_in[1] <= frame.payload.in_right;
          stb     <= frame.payload.samples_to_bar;
          ch      <= 1'b0;
          for (int i = 0; i < NCOEF; i++) begin
            tgt_in[i] <= coef_sat(nxt[i]);
          end
        end
      end
      rbcf_pkg::OP_LEN: begin
        // set up samples_to_bar modulo length
        len_reg    <= len_eff;
        resync_now <= resync_pending;
        div_rem    <= '0;
        div_bits   <= stb;
        div_den    <= len_eff;
        div_cnt    <= DCNT_W'(LEN_W);
      end
      rbcf_pkg::OP_DIV_STEP: begin
        div_rem  <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        div_bits <= {div_bits[LEN_W-2:0], 1'b0};
        div_quot <= {div_quot[LEN_W-2:0], ge};
        div_cnt  <= div_cnt - DCNT_W'(1);
      end
      rbcf_pkg::OP_LOAD: begin
        prod <= mul;
      end
      rbcf_pkg::OP_FADE_INIT: begin
        k <= rbcf_pkg::K_A0;
      end
      rbcf_pkg::OP_FMUL_T: begin
        prod <= mul;
      end
      rbcf_pkg::OP_FMUL_S: begin
        num  <= prod[NUM_W-1:0] + NUM_W'(smooth_span >> 1);
        prod <= mul;
      end
      rbcf_pkg::OP_FSUM: begin
        num <= num + prod[NUM_W-1:0];
      end
      rbcf_pkg::OP_FDIV_INIT: begin
        // quotient fits in COEF_W bits, so the top bits start as remainder
        div_rem  <= num[NUM_W-1:COEF_W];
        div_bits <= {num[COEF_W-1:0], {(LEN_W - COEF_W){1'b0}}};
        div_den  <= smooth_span;
        div_cnt  <= DCNT_W'(COEF_W);
      end
      rbcf_pkg::OP_FSTORE: begin
        k <= k + rbcf_pkg::coef_idx_t'(1);
      end
      rbcf_pkg::OP_FILT_INIT: begin
        acc <= '0;
        j   <= rbcf_pkg::K_A0;
      end
      rbcf_pkg::OP_MAC_MUL: begin
        prod <= mul;
      end
      rbcf_pkg::OP_MAC_ADD: begin
        // feedforward terms add, feedback terms subtract
        acc <= (j < rbcf_pkg::K_B1) ? acc + ACC_W'(prod) : acc - ACC_W'(prod);
        j   <= j + rbcf_pkg::coef_idx_t'(1);
      end
      rbcf_pkg::OP_ROUND: begin
        y_out[ch] <= y_sat;
        ch        <= ch + 1'b1;
      end
      rbcf_pkg::OP_EMIT: begin
        if (emit_fire) begin
          res_q.out_left  <= y_out[0];
          res_q.out_right <= y_out[1];
          res_q.coef_a0   <= live[rbcf_pkg::K_A0];
          res_q.coef_a1   <= live[rbcf_pkg::K_A1];
          res_q.coef_a2   <= live[rbcf_pkg::K_A2];
          res_q.coef_b1   <= live[rbcf_pkg::K_B1];
          res_q.coef_b2   <= live[rbcf_pkg::K_B2];
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/tb.sv]
// Self-checking bench for random_biquad_crossfade_filter: directed and random
// stereo frames against a bit-exact predictor of the crossfading biquad.
// Depends on rbcf_pkg, rbcf_stream_if and the filter top level.
`timescale 1ns / 1ps

module tb;

  localparam int     SAMPLE_W   = rbcf_pkg::SAMPLE_W;
  localparam int     COEF_W     = rbcf_pkg::COEF_W;
  localparam int     COEF_FRAC  = rbcf_pkg::COEF_FRAC;
  localparam int     LEN_W      = rbcf_pkg::LEN_W;
  localparam int     NCOEF      = rbcf_pkg::NCOEF;
  localparam int     NCHAN      = rbcf_pkg::NCHAN;
  localparam longint Q_ONE      = longint'(1) << COEF_FRAC;
  localparam longint Q_HALF     = longint'(1) << (COEF_FRAC - 1);
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));
  localparam int     LIMIT_CYCLES = 1000000;
  localparam int     MAX_REPORTS  = 100;

  // Predicts the filter frame by frame and checks what comes back
  class filter_scoreboard;
    longint x_hist [NCHAN][2];
    longint y_hist [NCHAN][2];
    longint live_set [NCOEF];
    longint start_set [NCOEF];
    longint target_set [NCOEF];
    longint cycle_left;
    longint fade_left;
    longint fade_span;
    bit     resync_pending;
    longint cycle_length;
    longint smooth_fraction;
    bit     host_sync;
    rbcf_pkg::result_t future_outputs [$];
    int     errors;

    function new();
      for (int ch = 0; ch < NCHAN; ch++) begin
        x_hist[ch] = '{0, 0};
        y_hist[ch] = '{0, 0};
      end
      for (int k = 0; k < NCOEF; k++) begin
        live_set[k]   = Q_HALF;
        start_set[k]  = 0;
        target_set[k] = 0;
      end
      cycle_left      = 1;
      fade_left       = 1;
      fade_span       = 1;
      resync_pending  = 1'b1;
      cycle_length    = 24000;
      smooth_fraction = 1966;
      host_sync       = 1'b1;
      errors          = 0;
    endfunction

    function void write_reg(rbcf_pkg::reg_index_t idx, logic [LEN_W-1:0] data);
      case (idx)
        rbcf_pkg::REG_CYCLE_LENGTH:    cycle_length = data;
        rbcf_pkg::REG_SMOOTH_FRACTION: smooth_fraction = data[COEF_W-1:0];
        rbcf_pkg::REG_HOST_SYNC:       host_sync = data[0];
        default: ;
      endcase
    endfunction

    // Advance the filter by one frame and queue the result it must give
    function void note_frame(rbcf_pkg::frame_t f);
      longint  len;
      longint  frac;
      longint  ss;
      longint  s;
      longint  acc;
      longint  r;
      longint  nxt [NCOEF];
      longint  x [NCHAN];
      longint  y [NCHAN];
      rbcf_pkg::result_t res;
      nxt[rbcf_pkg::K_A0] = f.next_a0;
      nxt[rbcf_pkg::K_A1] = f.next_a1;
      nxt[rbcf_pkg::K_A2] = f.next_a2;
      nxt[rbcf_pkg::K_B1] = f.next_b1;
      nxt[rbcf_pkg::K_B2] = f.next_b2;
      x[0] = $signed(f.in_left);
      x[1] = $signed(f.in_right);

      if (host_sync) begin
        if (f.playback_restart) begin
          resync_pending = 1'b1;
          cycle_left = 0;
        end
      end else begin
        resync_pending = 1'b0;
      end

      // cycle start: new length, span, start and target sets
      cycle_left--;
      if (cycle_left <= 0) begin
        len  = (cycle_length == 0) ? 1 : cycle_length;
        frac = (smooth_fraction > Q_ONE) ? Q_ONE : smooth_fraction;
        if (resync_pending) begin
          resync_pending = 1'b0;
          len = longint'(f.samples_to_bar) % len;
        end
        cycle_left = len;
        ss = (len * frac + Q_HALF) >> COEF_FRAC;
        fade_left = ss;
        fade_span = (ss != 0) ? ss : 1;
        for (int k = 0; k < NCOEF; k++) begin
          start_set[k]  = live_set[k];
          target_set[k] = (nxt[k] > Q_ONE) ? Q_ONE : nxt[k];
        end
      end

      // linear crossfade, rounded half up
      if (fade_left >= 0) begin
        s = (fade_left > fade_span) ? fade_span : fade_left;
        for (int k = 0; k < NCOEF; k++)
          live_set[k] = (target_set[k] * (fade_span - s) + start_set[k] * s
                         + (fade_span >> 1)) / fade_span;
        fade_left--;
      end

      // direct form I per channel
      for (int ch = 0; ch < NCHAN; ch++) begin
        acc = x[ch] * live_set[rbcf_pkg::K_A0]
            + x_hist[ch][0] * live_set[rbcf_pkg::K_A1]
            + x_hist[ch][1] * live_set[rbcf_pkg::K_A2]
            - y_hist[ch][0] * live_set[rbcf_pkg::K_B1]
            - y_hist[ch][1] * live_set[rbcf_pkg::K_B2];
        r = (acc + Q_HALF) >>> COEF_FRAC;
        if (r > SAMPLE_MAX) r = SAMPLE_MAX;
        else if (r < SAMPLE_MIN) r = SAMPLE_MIN;
        x_hist[ch][1] = x_hist[ch][0];
        x_hist[ch][0] = x[ch];
        y_hist[ch][1] = y_hist[ch][0];
        y_hist[ch][0] = r;
        y[ch] = r;
      end

      res.out_left  = y[0][SAMPLE_W-1:0];
      res.out_right = y[1][SAMPLE_W-1:0];
      res.coef_a0   = live_set[rbcf_pkg::K_A0][COEF_W-1:0];
      res.coef_a1   = live_set[rbcf_pkg::K_A1][COEF_W-1:0];
      res.coef_a2   = live_set[rbcf_pkg::K_A2][COEF_W-1:0];
      res.coef_b1   = live_set[rbcf_pkg::K_B1][COEF_W-1:0];
      res.coef_b2   = live_set[rbcf_pkg::K_B2][COEF_W-1:0];
      future_outputs.push_back(res);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(rbcf_pkg::result_t got);
      rbcf_pkg::result_t want;
      if (future_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("result request with no frame outstanding");
        return;
      end
      want = future_outputs.pop_front();
      check_field("out_left",  $signed(want.out_left),  $signed(got.out_left));
      check_field("out_right", $signed(want.out_right), $signed(got.out_right));
      check_field("coef_a0", want.coef_a0, got.coef_a0);
      check_field("coef_a1", want.coef_a1, got.coef_a1);
      check_field("coef_a2", want.coef_a2, got.coef_a2);
      check_field("coef_b1", want.coef_b1, got.coef_b1);
      check_field("coef_b2", want.coef_b2, got.coef_b2);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 wr_en;
  rbcf_pkg::reg_index_t wr_index;
  logic [LEN_W-1:0]     wr_data;

  rbcf_stream_if #(.payload_t(rbcf_pkg::frame_t))  frame_if ();
  rbcf_stream_if #(.payload_t(rbcf_pkg::result_t)) result_if ();

  filter_scoreboard sb = new();
  bit               no_idle = 1'b0;
  int               stall_left = 0;
  int unsigned      cycles = 0;

  random_biquad_crossfade_filter dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .frame    (frame_if),
    .result   (result_if)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_W'(SAMPLE_MAX);
      1:       return SAMPLE_W'(SAMPLE_MIN);
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return rbcf_pkg::COEF_ONE;
      2:       return COEF_W'($urandom_range(65537, 131071));
      3:       return COEF_W'($urandom_range(0, 4096));
      default: return COEF_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic rbcf_pkg::frame_t random_frame(longint len);
    rbcf_pkg::frame_t f;
    longint period;
    period = (len == 0) ? 1 : len;
    f.in_left          = rand_sample();
    f.in_right         = rand_sample();
    f.next_a0          = rand_coef();
    f.next_a1          = rand_coef();
    f.next_a2          = rand_coef();
    f.next_b1          = rand_coef();
    f.next_b2          = rand_coef();
    f.playback_restart = ($urandom_range(0, 11) == 0);
    // bar distances: exact multiples (zero remainder), short, or anything
    case ($urandom_range(0, 3))
      0:       f.samples_to_bar =
                 LEN_W'(period * $urandom_range(0, 32'(16777215 / period)));
      1:       f.samples_to_bar = LEN_W'($urandom_range(0, 64));
      default: f.samples_to_bar = LEN_W'($urandom);
    endcase
    return f;
  endfunction

  function automatic rbcf_pkg::frame_t make_frame(longint l, longint r, longint a0,
                                                  longint a1, longint a2, longint b1,
                                                  longint b2, bit restart, longint bar);
    rbcf_pkg::frame_t f;
    f.in_left          = l[SAMPLE_W-1:0];
    f.in_right         = r[SAMPLE_W-1:0];
    f.next_a0          = a0[COEF_W-1:0];
    f.next_a1          = a1[COEF_W-1:0];
    f.next_a2          = a2[COEF_W-1:0];
    f.next_b1          = b1[COEF_W-1:0];
    f.next_b2          = b2[COEF_W-1:0];
    f.playback_restart = restart;
    f.samples_to_bar   = bar[LEN_W-1:0];
    return f;
  endfunction

  // Present one frame request, then hold off for the next one. Valid stays
  // high when the next frame follows back to back.
  task automatic send_frame(input rbcf_pkg::frame_t f);
    int gap;
    frame_if.valid   <= 1'b1;
    frame_if.payload <= f;
    do @(posedge clk); while (!frame_if.ready);
    sb.note_frame(f);
    gap = pick_gap();
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain(input int settle);
    frame_if.valid <= 1'b0;
    while (sb.future_outputs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_config(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] frac,
                              input logic [LEN_W-1:0] sync);
    wr_en    <= 1'b1;
    wr_index <= rbcf_pkg::REG_CYCLE_LENGTH;
    wr_data  <= len;
    @(posedge clk);
    sb.write_reg(rbcf_pkg::REG_CYCLE_LENGTH, len);
    wr_index <= rbcf_pkg::REG_SMOOTH_FRACTION;
    wr_data  <= frac;
    @(posedge clk);
    sb.write_reg(rbcf_pkg::REG_SMOOTH_FRACTION, frac);
    wr_index <= rbcf_pkg::REG_HOST_SYNC;
    wr_data  <= sync;
    @(posedge clk);
    sb.write_reg(rbcf_pkg::REG_HOST_SYNC, sync);
    wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] frac,
                           input logic [LEN_W-1:0] sync, input int count,
                           input bit steady);
    apply_config(len, frac, sync);
    no_idle = steady || ($urandom_range(0, 4) == 0);
    repeat (count) send_frame(random_frame(len));
    drain(8);
  endtask

  // Result side: random stalls, accepted results go to the checker
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready)
        sb.check_result(result_if.payload);
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 19))
            0:       stall_left = $urandom_range(40, 150);
            1, 2, 3,
            4, 5:    stall_left = $urandom_range(3, 10);
            default: stall_left = $urandom_range(1, 2);
          endcase
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    wr_en            <= 1'b0;
    wr_index         <= rbcf_pkg::REG_CYCLE_LENGTH;
    wr_data          <= '0;
    frame_if.valid   <= 1'b0;
    frame_if.payload <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, resync pending: a bar distance that divides the cycle
    // gives a zero-length cycle and a zero span
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, 65536, 0, 0, 0, 0, 0, 48000));
    // coefficients above one saturate when taken
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, 131071, 131071, 65537, 131071,
                          131071, 0, 0));
    send_frame(make_frame(0, -1, 0, 0, 0, 0, 0, 1, 16777215));
    send_frame(make_frame(-1, 0, 1, 1, 1, 1, 1, 1, 0));
    send_frame(make_frame(1, SAMPLE_MAX, 65536, 32768, 16384, 0, 65536, 0, 5));
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, 0, 0, 0, 0));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MIN, 65536, 65536, 65536, 65536, 65536,
                          0, 12));
    send_frame(make_frame(-12345, 4567890, 1000, 2000, 3000, 4000, 5000, 0, 77));
    drain(8);

    // Zero cycle length, fraction above one, resync disabled; upper data
    // bits set to check they are ignored
    apply_config(24'd0, {7'h7f, 17'h1ffff}, 24'hfffffe);
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, 65536, 65536, 65536, 65536, 65536,
                          1, 3));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MIN, 131071, 0, 65537, 1, 98304,
                          1, 16777215));
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, 65536, 0, 0, 65536, 65536, 0, 0));
    send_frame(make_frame(0, 0, 40000, 20000, 10000, 30000, 5000, 1, 100));
    send_frame(make_frame(123456, -654321, 65535, 1, 32768, 32767, 0, 0, 9));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, 0, 0, 0, 0, 0, 0, 0));
    drain(8);

    // Random frames over a range of settings
    run_phase(24'd5, 24'd32768, 24'd1, 90, 1'b0);
    run_phase(24'd1, 24'd0, 24'd1, 80, 1'b1);
    run_phase(24'hffffff, 24'd65536, 24'd1, 60, 1'b0);
    run_phase(24'd24000, 24'd1966, 24'd1, 60, 1'b0);
    run_phase(LEN_W'($urandom_range(2, 40)),
              LEN_W'($urandom_range(0, 131071)) | (LEN_W'($urandom_range(0, 127)) << 17),
              (LEN_W'($urandom) & 24'hfffffe) | 24'd1, 90, 1'b0);
    run_phase(LEN_W'($urandom_range(1, 12)),
              LEN_W'($urandom_range(0, 131071)) | (LEN_W'($urandom_range(0, 127)) << 17),
              LEN_W'($urandom) & 24'hfffffe, 80, 1'b0);
    run_phase(24'd3, 24'd100000, 24'd1, 90, 1'b0);

    drain(200);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
